[src/tsp_pkg.sv]
// ============================================================================
// tsp_pkg
// Shared types and constants for the timestamp to second/period converter.
// ============================================================================
`default_nettype none

package tsp_pkg;

  // Microseconds in one second and the field widths of the results.
  localparam logic [31:0] US_PER_SEC = 32'd1000000;
  localparam int unsigned SUB_W      = 20;
  localparam int unsigned OUT_PER_W  = 4;
  localparam int unsigned SHORT_W    = 24;

  // Reciprocal of one million: q = (x * RECIP_M) >> RECIP_SHIFT is exact for
  // every 32-bit x.
  localparam logic [30:0] RECIP_M     = 31'd1125899907;
  localparam int unsigned RECIP_SHIFT = 50;
  localparam int unsigned PROD_W      = 63;
  localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam logic [31:0] PERIOD_LEN_RESET = 32'd60000;

  typedef enum logic [1:0] {
    REG_BASE_VALID = 2'd0,
    REG_BASE_MARK  = 2'd1,
    REG_BASE_SEC   = 2'd2,
    REG_PERIOD_LEN = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic        base_valid;
    logic [31:0] base_mark_us;
    logic [31:0] base_second;
    logic [31:0] period_len_us;
  } tsp_cfg_t;

  typedef struct packed {
    logic [31:0]      seconds;
    logic [SUB_W-1:0] sub_us;
  } tsp_sec_t;

endpackage

`default_nettype wire

[src/timestamp_to_second_period_core.sv]
// ============================================================================
// timestamp_to_second_period_core
// Converts a monotonic microsecond count into seconds, sub-second remainder,
// period index and packed second stamps.
// ============================================================================
//
//  Channel  Direction  Handshake           Payload
//  in_      input      in_valid/in_ready   now_us
//  out_     output     out_valid/out_ready seconds, sub_second_us, period_index,
//                                          packed_stamp, short_stamp
//  cfg      input      psel/penable/pready base_valid, base_mark_us,
//                                          base_second, period_len_us
//
//  One item enters per cycle while the output does not stall. The path has
//  four stages for the reciprocal divide by one million, then one stage per
//  period bit plus a saturation check in the period divider.
//  Synchronous reset clears all valid bits; config registers take reset values.
//  Each stage holds its item while the one after it is full and stalled, so a
//  stall on the output fills bubbles first and loses or repeats no transfer.
//
`default_nettype none

module timestamp_to_second_period_core #(
  parameter int unsigned PERIOD_BITS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_now_us,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_seconds,
  output logic [19:0]      out_sub_second_us,
  output logic [3:0]       out_period_index,
  output logic [31:0]      out_packed_stamp,
  output logic [23:0]      out_short_stamp
);

  tsp_pkg::tsp_cfg_t      cfg_r;
  tsp_pkg::reg_idx_t      reg_idx;
  logic                   wr_en;
  logic                   split_valid;
  logic                   split_ready;
  tsp_pkg::tsp_sec_t      split_data;
  tsp_pkg::tsp_sec_t      div_data;
  logic [PERIOD_BITS-1:0] period;
  logic [7:0]             period_ext;

  assign pready  = 1'b1;
  assign reg_idx = tsp_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_valid    <= 1'b0;
      cfg_r.base_mark_us  <= '0;
      cfg_r.base_second   <= '0;
      cfg_r.period_len_us <= tsp_pkg::PERIOD_LEN_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        tsp_pkg::REG_BASE_VALID: cfg_r.base_valid    <= pwdata[0];
        tsp_pkg::REG_BASE_MARK:  cfg_r.base_mark_us  <= pwdata;
        tsp_pkg::REG_BASE_SEC:   cfg_r.base_second   <= pwdata;
        tsp_pkg::REG_PERIOD_LEN: cfg_r.period_len_us <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tsp_pkg::REG_BASE_VALID: prdata = {31'd0, cfg_r.base_valid};
      tsp_pkg::REG_BASE_MARK:  prdata = cfg_r.base_mark_us;
      tsp_pkg::REG_BASE_SEC:   prdata = cfg_r.base_second;
      tsp_pkg::REG_PERIOD_LEN: prdata = cfg_r.period_len_us;
      default:                 prdata = '0;
    endcase
  end

  tsp_sec_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .now_us    (in_now_us),
    .out_valid (split_valid),
    .out_ready (split_ready),
    .out_data  (split_data)
  );

  tsp_period_div #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (split_valid),
    .in_ready   (split_ready),
    .in_data    (split_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (div_data),
    .out_period (period)
  );

  // The index port is four bits whatever the period field width.
  assign period_ext        = 8'(period);
  assign out_seconds       = div_data.seconds;
  assign out_sub_second_us = div_data.sub_us;
  assign out_period_index  = period_ext[3:0];
  assign out_packed_stamp  = {period, div_data.seconds[31-PERIOD_BITS:0]};
  assign out_short_stamp   = div_data.seconds[tsp_pkg::SHORT_W-1:0];

  a_sub_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_sub_second_us) < tsp_pkg::US_PER_SEC))
    else $error("sub-second count out of range");

  a_empty_accepts : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("empty pipeline refuses a transfer");

  a_zero_len_period : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (cfg_r.period_len_us == 32'd0)) |-> (out_period_index == 4'd0))
    else $error("non-zero period for zero period length");

endmodule

`default_nettype wire

[src/tsp_sec_split.sv]
// ============================================================================
// tsp_sec_split
// Four-stage split of the elapsed microsecond count into seconds and remainder.
// ============================================================================
`default_nettype none

module tsp_sec_split (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tsp_pkg::tsp_cfg_t cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [31:0]       now_us,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tsp_pkg::tsp_sec_t      out_data
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [31:0]                  el1_r, el2_r, el3_r;
  logic [31:0]                  el1_nxt;
  logic [tsp_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  logic [tsp_pkg::QUOT_W-1:0]   q3_r, q3_nxt;
  logic [31:0]                  qm3_r, qm3_nxt;
  tsp_pkg::tsp_sec_t            d4_r, d4_nxt;

  // A stage takes new data when it is empty or its successor moves on.
  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign el1_nxt  = cfg.base_valid ? (now_us - cfg.base_mark_us) : now_us;
  assign prod_nxt = tsp_pkg::PROD_W'(el1_r) * tsp_pkg::PROD_W'(tsp_pkg::RECIP_M);
  assign q3_nxt   = prod_r[tsp_pkg::PROD_W-1:tsp_pkg::RECIP_SHIFT];
  assign qm3_nxt  = 32'(q3_nxt) * tsp_pkg::US_PER_SEC;

  always_comb begin
    d4_nxt.sub_us  = tsp_pkg::SUB_W'(el3_r - qm3_r);
    d4_nxt.seconds = cfg.base_valid ? (cfg.base_second + 32'(q3_r)) : 32'(q3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      el1_r <= el1_nxt;
    end
    if (rdy2 && v1_r) begin
      prod_r <= prod_nxt;
      el2_r  <= el1_r;
    end
    if (rdy3 && v2_r) begin
      q3_r  <= q3_nxt;
      qm3_r <= qm3_nxt;
      el3_r <= el2_r;
    end
    if (rdy4 && v3_r) begin
      d4_r <= d4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = d4_r;

endmodule

`default_nettype wire

[src/tsp_period_div.sv]
// ============================================================================
// tsp_period_div
// Pipelined restoring division of the sub-second count by the period length:
// a saturation check, then one bit per stage, saturating at the field maximum.
// ============================================================================
`default_nettype none

module tsp_period_div #(
  parameter int unsigned PERIOD_BITS = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire tsp_pkg::tsp_cfg_t      cfg,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire tsp_pkg::tsp_sec_t      in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output tsp_pkg::tsp_sec_t           out_data,
  output logic [PERIOD_BITS-1:0]      out_period
);

  // The first stage only checks for saturation; the rest each give one bit.
  localparam int unsigned NS = PERIOD_BITS + 1;
  localparam int unsigned DW = 32 + PERIOD_BITS;
  localparam int unsigned SW = tsp_pkg::SUB_W;

  logic [NS:0]            rdy;
  logic                   v_r   [NS];
  tsp_pkg::tsp_sec_t      d_r   [NS];
  logic [SW-1:0]          rem_r [NS];
  logic [PERIOD_BITS-1:0] q_r   [NS];
  logic                   sat_r [NS];

  assign rdy[NS]  = out_ready;
  assign in_ready = rdy[0];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    localparam int unsigned K = PERIOD_BITS - j;

    logic                   src_v;
    tsp_pkg::tsp_sec_t      src_d;
    logic [SW-1:0]          src_rem;
    logic [PERIOD_BITS-1:0] src_q;
    logic                   src_sat;
    logic [DW-1:0]          dv;
    logic                   ge;
    logic [SW-1:0]          rem_nxt;
    logic [PERIOD_BITS-1:0] q_nxt;
    logic                   sat_nxt;

    if (j == 0) begin : g_first
      assign src_v   = in_valid;
      assign src_d   = in_data;
      assign src_rem = in_data.sub_us;
      assign src_q   = '0;
      assign src_sat = 1'b0;
    end else begin : g_next
      assign src_v   = v_r[j-1];
      assign src_d   = d_r[j-1];
      assign src_rem = rem_r[j-1];
      assign src_q   = q_r[j-1];
      assign src_sat = sat_r[j-1];
    end

    assign rdy[j] = !v_r[j] || rdy[j+1];
    assign dv     = DW'(cfg.period_len_us) << K;
    assign ge     = DW'(src_rem) >= dv;

    always_comb begin
      rem_nxt = src_rem;
      q_nxt   = src_q;
      sat_nxt = src_sat;
      if (K == PERIOD_BITS) begin
        sat_nxt = ge;
      end else if (ge && !src_sat) begin
        rem_nxt = src_rem - dv[SW-1:0];
        q_nxt   = src_q | (PERIOD_BITS'(1) << K);
      end
      // A zero length gives period zero; an overflowing quotient saturates.
      if (j == NS - 1) begin
        if (cfg.period_len_us == 32'd0) begin
          q_nxt = '0;
        end else if (sat_nxt) begin
          q_nxt = '1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_r[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j] && src_v) begin
        d_r[j]   <= src_d;
        rem_r[j] <= rem_nxt;
        q_r[j]   <= q_nxt;
        sat_r[j] <= sat_nxt;
      end
    end
  end

  assign out_valid  = v_r[NS-1];
  assign out_data   = d_r[NS-1];
  assign out_period = q_r[NS-1];

endmodule

`default_nettype wire

[dv/timestamp_to_second_period_core_tb.sv]
// ============================================================================
// timestamp_to_second_period_core_tb
// Self-checking bench for the microsecond to second/period converter. A short
// table of directed conversions and register settings runs first, followed by
// randomised phases that reprogram the base and period registers while idle
// and convert random timestamps and ones around second and period boundaries.
// Every result transfer is checked against a hand-worked value or a local model.
// ============================================================================
`default_nettype none

module timestamp_to_second_period_core_tb;

  localparam int unsigned PER_BITS  = 4;
  localparam int unsigned PER_SHIFT = 32 - PER_BITS;
  localparam logic [31:0] PER_MAX   = (32'd1 << PER_BITS) - 32'd1;
  localparam logic [31:0] SEC_MASK  = (32'd1 << PER_SHIFT) - 32'd1;
  localparam int unsigned LATENCY   = 5 + PER_BITS;
  localparam int unsigned N_PHASES  = 25;
  localparam int unsigned PHASE_LEN = 70;
  localparam int unsigned LIMIT     = 400000;
  localparam int unsigned N_DIR     = 31;

  typedef struct packed {
    logic [31:0] seconds;
    logic [19:0] sub_second_us;
    logic [3:0]  period_index;
    logic [31:0] packed_stamp;
    logic [23:0] short_stamp;
  } stamp_t;

  // One row of the directed table: either a register write or a conversion,
  // the latter with an optional hand-worked result.
  typedef struct {
    bit                 is_write;
    tsp_pkg::reg_idx_t  idx;
    logic [31:0]        value;
    bit                 typed;
    stamp_t             want;
  } dir_row_t;

  localparam stamp_t NO_STAMP = '0;

  dir_row_t dir_tab [N_DIR] = '{
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'd0, 1'b1, '{32'd0, 20'd0, 4'd0, 32'h0, 24'h0}},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'd999999, 1'b1,
      '{32'd0, 20'd999999, 4'd15, 32'hF000_0000, 24'h0}},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'd1000000, 1'b1,
      '{32'd1, 20'd0, 4'd0, 32'h1, 24'h1}},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'hFFFF_FFFF, 1'b1,
      '{32'd4294, 20'd967295, 4'd15, 32'hF000_10C6, 24'h0010C6}},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'd59999,      1'b0, NO_STAMP},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'd60000,      1'b0, NO_STAMP},
    '{1'b1, tsp_pkg::REG_PERIOD_LEN, 32'd0,          1'b0, NO_STAMP},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'd999999,     1'b1,
      '{32'd0, 20'd999999, 4'd0, 32'h0, 24'h0}},
    '{1'b1, tsp_pkg::REG_PERIOD_LEN, 32'd1,          1'b0, NO_STAMP},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'd500000,     1'b0, NO_STAMP},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'd0,          1'b0, NO_STAMP},
    '{1'b1, tsp_pkg::REG_PERIOD_LEN, 32'hFFFF_FFFF,  1'b0, NO_STAMP},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'hFFFF_FFFF,  1'b0, NO_STAMP},
    '{1'b1, tsp_pkg::REG_PERIOD_LEN, 32'd62500,      1'b0, NO_STAMP},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'd999999,     1'b0, NO_STAMP},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'd937499,     1'b0, NO_STAMP},
    // An oversized value keeps only bit 0 of the base-valid flag.
    '{1'b1, tsp_pkg::REG_BASE_VALID, 32'hFFFF_FFFF,  1'b0, NO_STAMP},
    '{1'b1, tsp_pkg::REG_BASE_MARK,  32'h0000_0010,  1'b0, NO_STAMP},
    '{1'b1, tsp_pkg::REG_BASE_SEC,   32'hFFFF_FFFF,  1'b0, NO_STAMP},
    // Mark after now, then elapsed zero, then the seconds sum wrapping.
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'h0000_000F,  1'b0, NO_STAMP},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'h0000_0010,  1'b0, NO_STAMP},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'h002D_C6D0,  1'b0, NO_STAMP},
    '{1'b1, tsp_pkg::REG_BASE_MARK,  32'hFFFF_FFFF,  1'b0, NO_STAMP},
    '{1'b1, tsp_pkg::REG_BASE_SEC,   32'h00FF_FFFF,  1'b0, NO_STAMP},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'hFFFF_FFFF,  1'b0, NO_STAMP},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'h0000_0000,  1'b0, NO_STAMP},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'h000F_4240,  1'b0, NO_STAMP},
    '{1'b1, tsp_pkg::REG_BASE_VALID, 32'hFFFF_FFFE,  1'b0, NO_STAMP},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'd5000000,    1'b0, NO_STAMP},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'hAAAA_AAAA,  1'b0, NO_STAMP},
    '{1'b0, tsp_pkg::REG_BASE_VALID, 32'h5555_5555,  1'b0, NO_STAMP}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_now_us = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [31:0] out_seconds;
  logic [19:0] out_sub_second_us;
  logic [3:0]  out_period_index;
  logic [31:0] out_packed_stamp;
  logic [23:0] out_short_stamp;

  tsp_pkg::tsp_cfg_t cfg_shadow;
  stamp_t      stamp_q [$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_writes = 0;
  int unsigned cycles = 0;
  int unsigned idle_rate = 0;
  int unsigned stall_rate = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;

  timestamp_to_second_period_core #(
    .PERIOD_BITS (PER_BITS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_now_us         (in_now_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_seconds       (out_seconds),
    .out_sub_second_us (out_sub_second_us),
    .out_period_index  (out_period_index),
    .out_packed_stamp  (out_packed_stamp),
    .out_short_stamp   (out_short_stamp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Seconds, remainder, period index and both stamps of one timestamp under
  // the currently programmed registers.
  function automatic stamp_t convert_stamp(logic [31:0] now);
    stamp_t      r;
    logic [31:0] elapsed;
    logic [31:0] secs;
    logic [31:0] sub;
    logic [31:0] period;
    elapsed = cfg_shadow.base_valid ? now - cfg_shadow.base_mark_us : now;
    secs    = elapsed / tsp_pkg::US_PER_SEC;
    if (cfg_shadow.base_valid) begin
      secs = secs + cfg_shadow.base_second;
    end
    sub    = elapsed % tsp_pkg::US_PER_SEC;
    period = '0;
    if (cfg_shadow.period_len_us != 0) begin
      period = sub / cfg_shadow.period_len_us;
      if (period > PER_MAX) begin
        period = PER_MAX;
      end
    end
    r.seconds       = secs;
    r.sub_second_us = sub[19:0];
    r.period_index  = period[3:0];
    r.packed_stamp  = ((period & PER_MAX) << PER_SHIFT) | (secs & SEC_MASK);
    r.short_stamp   = secs[23:0];
    return r;
  endfunction

  // Timestamps clustered around second and period boundaries of the
  // current base, with plain random values and the wrap points mixed in.
  function automatic logic [31:0] pick_now();
    logic [31:0] origin;
    logic [31:0] whole;
    logic [31:0] r;
    origin = cfg_shadow.base_valid ? cfg_shadow.base_mark_us : 32'd0;
    whole  = origin + $urandom_range(0, 4294) * tsp_pkg::US_PER_SEC;
    case ($urandom_range(0, 5))
      0, 1: r = $urandom;
      2: r = whole + $urandom_range(0, 999999);
      3: r = whole + (($urandom_range(0, 1) != 0) ? 32'd999999 : 32'($urandom_range(0, 1)));
      4: r = whole + $urandom_range(0, 16) * cfg_shadow.period_len_us - $urandom_range(0, 1);
      default: begin
        case ($urandom_range(0, 3))
          0: r = 32'd0;
          1: r = 32'hFFFF_FFFF;
          2: r = origin - 32'd1;
          default: r = origin;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_reg_value(tsp_pkg::reg_idx_t idx);
    logic [31:0] r;
    r = $urandom;
    case (idx)
      tsp_pkg::REG_BASE_VALID: if ($urandom_range(0, 3) != 0) r = 32'($urandom_range(0, 1));
      tsp_pkg::REG_BASE_MARK, tsp_pkg::REG_BASE_SEC: begin
        case ($urandom_range(0, 5))
          0: r = 32'd0;
          1: r = 32'hFFFF_FFFF - $urandom_range(0, 3);
          default: ;
        endcase
      end
      tsp_pkg::REG_PERIOD_LEN: begin
        case ($urandom_range(0, 7))
          0: r = 32'd0;
          1: r = 32'd1;
          2, 3: r = $urandom_range(1, 70000);
          4: r = $urandom_range(50000, 1000000);
          5: r = 32'd62500;
          6: r = 32'hFFFF_FFFF;
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  // Write a register, then read it back. Called at a falling edge with the
  // converter idle; returns at a falling edge.
  task automatic put_reg(tsp_pkg::reg_idx_t idx, logic [31:0] value);
    logic [31:0] kept;
    kept = value;
    case (idx)
      tsp_pkg::REG_BASE_VALID: begin
        kept = {31'd0, value[0]};
        cfg_shadow.base_valid = value[0];
      end
      tsp_pkg::REG_BASE_MARK:  cfg_shadow.base_mark_us = value;
      tsp_pkg::REG_BASE_SEC:   cfg_shadow.base_second = value;
      tsp_pkg::REG_PERIOD_LEN: cfg_shadow.period_len_us = value;
      default: ;
    endcase
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", kept, prdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    n_writes++;
  endtask

  // Hold the sender until every expected result has been seen.
  task automatic drain();
    in_valid = 1'b0;
    while (stamp_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_now(logic [31:0] now, bit typed, stamp_t fixed);
    in_now_us = now;
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
    stamp_q.push_back(typed ? fixed : convert_stamp(now));
    n_sent++;
    @(negedge clk);
    if (!quiet && idle_rate != 0 && $urandom_range(0, idle_rate - 1) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycles, stamp_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    stamp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (stamp_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result transfer, expected none, got seconds %h",
                 $time, out_seconds);
      end else begin
        want = stamp_q.pop_front();
        check_field("seconds", want.seconds, out_seconds);
        check_field("sub_second_us", 32'(want.sub_second_us), 32'(out_sub_second_us));
        check_field("period_index", 32'(want.period_index), 32'(out_period_index));
        check_field("packed_stamp", want.packed_stamp, out_packed_stamp);
        check_field("short_stamp", 32'(want.short_stamp), 32'(out_short_stamp));
        n_checked++;
      end
    end
  end

  // Back-pressure on the result side, in bursts whose density is redrawn
  // periodically from three settings, including stretches with none at all.
  always @(negedge clk) begin
    if (cycles % 128 == 0) begin
      case ($urandom_range(0, 2))
        0: stall_rate = 0;
        1: stall_rate = 3;
        default: stall_rate = 12;
      endcase
    end
    if (quiet) begin
      out_ready = 1'b1;
    end else if (stall_left != 0) begin
      out_ready  = 1'b0;
      stall_left = stall_left - 1;
    end else if (stall_rate != 0 && $urandom_range(0, stall_rate - 1) == 0) begin
      out_ready  = 1'b0;
      stall_left = $urandom_range(0, 16);
    end else begin
      out_ready = 1'b1;
    end
  end

  initial begin
    cfg_shadow = '{1'b0, 32'd0, 32'd0, tsp_pkg::PERIOD_LEN_RESET};
    repeat (4) @(negedge clk);
    rst_n     = 1'b1;
    idle_rate = 5;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_write) begin
        drain();
        put_reg(dir_tab[i].idx, dir_tab[i].value);
      end else begin
        send_now(dir_tab[i].value, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      put_reg(tsp_pkg::REG_BASE_VALID, pick_reg_value(tsp_pkg::REG_BASE_VALID));
      put_reg(tsp_pkg::REG_BASE_MARK, pick_reg_value(tsp_pkg::REG_BASE_MARK));
      put_reg(tsp_pkg::REG_BASE_SEC, pick_reg_value(tsp_pkg::REG_BASE_SEC));
      put_reg(tsp_pkg::REG_PERIOD_LEN, pick_reg_value(tsp_pkg::REG_PERIOD_LEN));
      case ($urandom_range(0, 2))
        0: idle_rate = 0;
        1: idle_rate = 4;
        default: idle_rate = 16;
      endcase
      // The closing phase runs at full rate on both sides.
      quiet = (p == N_PHASES - 1);
      for (int k = 0; k < PHASE_LEN; k++) begin
        send_now(pick_now(), 1'b0, NO_STAMP);
      end
    end

    drain();
    $display("Converted %0d timestamps over %0d register settings; %0d results checked.",
             n_sent, n_writes, n_checked);
    $display("Covered zero, unit and full-range period lengths with and without a base.");
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
src/tsp_pkg.sv
src/tsp_sec_split.sv
src/tsp_period_div.sv
src/timestamp_to_second_period_core.sv
dv/timestamp_to_second_period_core_tb.sv
